FILE: design/cfmb_pkg.sv
// ----------------------------------------------------------------------------
// cfmb_pkg: shared types and codes for the clipped fill and blit block
// Command and status codes, operation modes and the per-item step record
// passed from the step engine to the address stage.
// ----------------------------------------------------------------------------
package cfmb_pkg;

  localparam int unsigned FIELD_W = 12;  // coordinate and size field width
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned PIXEL_W = 8;

  // command codes (request tuser)
  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_BLIT  = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;

  // status codes (result tuser)
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_REJECT     = 2'd1;
  localparam logic [1:0] STAT_IDLE_PIXEL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_PITCH     = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FILL = 2'd1,
    MODE_BLIT = 2'd2
  } mode_t;

  // one processed request, before the address multiply
  typedef struct packed {
    logic [1:0]         status;
    logic               we;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [PIXEL_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } step_t;

endpackage

FILE: design/cfmb_engine.sv
// ----------------------------------------------------------------------------
// cfmb_engine: command decode, clipping and cursor stepping
// Holds the operation state, handles one request per cycle while adv is high
// and registers the resulting step record for the address stage.
// ----------------------------------------------------------------------------
module cfmb_engine import cfmb_pkg::*; #(
  parameter int unsigned CW = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_v,
  input  logic [1:0]          command,
  input  logic signed [15:0]  x_a,
  input  logic signed [15:0]  y_a,
  input  logic signed [15:0]  x_b,
  input  logic signed [15:0]  y_b,
  input  logic [CW-1:0]       block_width,
  input  logic [CW-1:0]       block_height,
  input  logic [PIXEL_W-1:0]  colour,
  input  logic                use_colour,
  input  logic [PIXEL_W-1:0]  pixel,
  input  logic [CW-1:0]       screen_width,
  input  logic [CW-1:0]       screen_height,
  input  logic [CW-1:0]       row_pitch,
  output logic                step_v_r,
  output step_t               step_r
);

  mode_t mode_r, mode_nxt;

  logic [CW-1:0]        clip_l_r, clip_t_r, clip_rt_r, clip_b_r;
  logic [CW-1:0]        clip_l_nxt, clip_t_nxt, clip_rt_nxt, clip_b_nxt;
  logic signed [15:0]   org_x_r, org_y_r, org_x_nxt, org_y_nxt;
  logic [CW-1:0]        span_w_r, span_h_r, span_w_nxt, span_h_nxt;
  logic [CW-1:0]        cur_col_r, cur_row_r, cur_col_nxt, cur_row_nxt;
  logic [PIXEL_W-1:0]   colour_r, colour_nxt;
  logic                 cmode_r, cmode_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  step_t                step_nxt;

  logic                 take;
  logic                 cfg_ok;
  logic signed [17:0]   ax, ay, bx, by;
  logic signed [17:0]   c_lx, c_hx, c_ly, c_hy;
  logic signed [17:0]   scr_w, scr_h;
  logic                 clip_empty;
  logic [CW-1:0]        cl_l, cl_t, cl_r, cl_b;
  logic signed [17:0]   dx, dy;
  logic                 in_clip;
  logic                 blit_wr;

  assign take   = adv && in_v;
  assign cfg_ok = (screen_width != '0) && (screen_height != '0) &&
                  (row_pitch >= screen_width);

  assign ax    = 18'(x_a);
  assign ay    = 18'(y_a);
  assign bx    = 18'(x_b);
  assign by    = 18'(y_b);
  assign scr_w = $signed(18'(screen_width));
  assign scr_h = $signed(18'(screen_height));

  // rectangle to clip: ordered fill corners, or the blit block
  always_comb begin
    if (command == CMD_FILL) begin
      c_lx = (ax < bx) ? ax : bx;
      c_hx = (ax > bx) ? ax : bx;
      c_ly = (ay < by) ? ay : by;
      c_hy = (ay > by) ? ay : by;
    end else begin
      c_lx = ax;
      c_ly = ay;
      c_hx = ax + $signed(18'(block_width)) - 18'sd1;
      c_hy = ay + $signed(18'(block_height)) - 18'sd1;
    end
  end

  assign clip_empty = (c_hx < 0) || (c_hy < 0) || (c_lx >= scr_w) || (c_ly >= scr_h);
  assign cl_l = (c_lx < 0) ? '0 : c_lx[CW-1:0];
  assign cl_t = (c_ly < 0) ? '0 : c_ly[CW-1:0];
  assign cl_r = (c_hx >= scr_w) ? (screen_width - 1'b1) : c_hx[CW-1:0];
  assign cl_b = (c_hy >= scr_h) ? (screen_height - 1'b1) : c_hy[CW-1:0];

  // destination of the current blit source pixel
  assign dx = 18'(org_x_r) + $signed(18'(cur_col_r));
  assign dy = 18'(org_y_r) + $signed(18'(cur_row_r));
  assign in_clip = (dx >= $signed(18'(clip_l_r))) && (dx <= $signed(18'(clip_rt_r))) &&
                   (dy >= $signed(18'(clip_t_r))) && (dy <= $signed(18'(clip_b_r)));
  assign blit_wr = in_clip && (!cmode_r || (pixel != '0));

  always_comb begin
    mode_nxt    = mode_r;
    clip_l_nxt  = clip_l_r;
    clip_t_nxt  = clip_t_r;
    clip_rt_nxt = clip_rt_r;
    clip_b_nxt  = clip_b_r;
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    span_w_nxt  = span_w_r;
    span_h_nxt  = span_h_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    colour_nxt  = colour_r;
    cmode_nxt   = cmode_r;
    count_nxt   = count_r;
    step_nxt    = '0;
    if (take) begin
      unique case (command)
        CMD_FILL: begin
          if (cfg_ok && !clip_empty) begin
            mode_nxt    = MODE_FILL;
            clip_l_nxt  = cl_l;
            clip_t_nxt  = cl_t;
            clip_rt_nxt = cl_r;
            clip_b_nxt  = cl_b;
            colour_nxt  = colour;
            cur_col_nxt = cl_l;
            cur_row_nxt = cl_t;
            count_nxt   = '0;
          end else begin
            mode_nxt        = MODE_IDLE;
            step_nxt.status = STAT_REJECT;
          end
        end
        CMD_BLIT: begin
          if ((block_width != '0) && (block_height != '0) && cfg_ok && !clip_empty) begin
            mode_nxt    = MODE_BLIT;
            clip_l_nxt  = cl_l;
            clip_t_nxt  = cl_t;
            clip_rt_nxt = cl_r;
            clip_b_nxt  = cl_b;
            org_x_nxt   = x_a;
            org_y_nxt   = y_a;
            span_w_nxt  = block_width;
            span_h_nxt  = block_height;
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            colour_nxt  = colour;
            cmode_nxt   = use_colour;
            count_nxt   = '0;
          end else begin
            mode_nxt        = MODE_IDLE;
            step_nxt.status = STAT_REJECT;
          end
        end
        CMD_PIXEL: begin
          unique case (mode_r)
            MODE_FILL: begin
              count_nxt      = count_r + 1'b1;
              step_nxt.we    = 1'b1;
              step_nxt.row   = FIELD_W'(cur_row_r);
              step_nxt.col   = FIELD_W'(cur_col_r);
              step_nxt.value = colour_r;
              step_nxt.count = count_nxt;
              if (cur_col_r >= clip_rt_r) begin
                if (cur_row_r >= clip_b_r) begin
                  step_nxt.last = 1'b1;
                  mode_nxt      = MODE_IDLE;
                end else begin
                  cur_col_nxt = clip_l_r;
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            MODE_BLIT: begin
              if (blit_wr) begin
                count_nxt      = count_r + 1'b1;
                step_nxt.we    = 1'b1;
                step_nxt.row   = FIELD_W'(dy[CW-1:0]);
                step_nxt.col   = FIELD_W'(dx[CW-1:0]);
                step_nxt.value = cmode_r ? colour_r : pixel;
              end
              step_nxt.count = count_nxt;
              if (({1'b0, cur_col_r} + 1'b1) >= {1'b0, span_w_r}) begin
                if (({1'b0, cur_row_r} + 1'b1) >= {1'b0, span_h_r}) begin
                  step_nxt.last = 1'b1;
                  mode_nxt      = MODE_IDLE;
                end else begin
                  cur_col_nxt = '0;
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            MODE_IDLE: begin
              step_nxt.status = STAT_IDLE_PIXEL;
            end
            default: begin
              step_nxt.status = STAT_IDLE_PIXEL;
            end
          endcase
        end
        default: begin
          step_nxt.status = STAT_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      step_v_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      if (adv) begin
        step_v_r <= in_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    clip_l_r  <= clip_l_nxt;
    clip_t_r  <= clip_t_nxt;
    clip_rt_r <= clip_rt_nxt;
    clip_b_r  <= clip_b_nxt;
    org_x_r   <= org_x_nxt;
    org_y_r   <= org_y_nxt;
    span_w_r  <= span_w_nxt;
    span_h_r  <= span_h_nxt;
    cur_col_r <= cur_col_nxt;
    cur_row_r <= cur_row_nxt;
    colour_r  <= colour_nxt;
    cmode_r   <= cmode_nxt;
    count_r   <= count_nxt;
    if (adv) begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/cfmb_addr.sv
// ----------------------------------------------------------------------------
// cfmb_addr: framebuffer address stage and result register
// Forms row times pitch plus column and holds the finished result.
// ----------------------------------------------------------------------------
module cfmb_addr import cfmb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                step_v,
  input  step_t               step,
  input  logic [FIELD_W-1:0]  row_pitch,
  output logic                out_v_r,
  output logic [1:0]          status_r,
  output logic                we_r,
  output logic [ADDR_W-1:0]   addr_r,
  output logic [PIXEL_W-1:0]  value_r,
  output logic [COUNT_W-1:0]  count_r,
  output logic                last_r
);

  logic [2*FIELD_W-1:0] prod;
  logic [ADDR_W-1:0]    addr_nxt;

  // row and column are zero when nothing is written, so the address is too
  assign prod     = step.row * row_pitch;
  assign addr_nxt = ADDR_W'(prod + (2*FIELD_W)'(step.col));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= step_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= step.status;
      we_r     <= step.we;
      addr_r   <= addr_nxt;
      value_r  <= step.value;
      count_r  <= step.count;
      last_r   <= step.last;
    end
  end

endmodule

FILE: design/clipped_fill_and_masked_blit_top.sv
// ----------------------------------------------------------------------------
// clipped_fill_and_masked_blit_top: clipped rectangle fill and masked blit
// Streams one result per request: framebuffer byte writes for fills and
// blits clipped to the configured screen.
// ----------------------------------------------------------------------------
// A fill or blit start request sets up a clipped operation; each following
// pixel request yields one result carrying the write enable, byte address
// (row * row_pitch + column), byte value, running write count and a last
// flag. The block takes one request per clock unless a finished result
// waits on out_tready, and returns one result per request in order: the
// request passes the input register, the step engine register and the
// result register, which all advance together; the step register stands
// in front of the row * pitch multiply. in_tready drops only while a
// finished result waits on out_tready. Configuration writes are taken on
// any cycle but belong to idle periods.
module clipped_fill_and_masked_blit_top import cfmb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_tvalid,
  output logic          in_tready,
  // [15:0] x_a, [31:16] y_a, [47:32] x_b, [63:48] y_b, [75:64] block_width,
  // [87:76] block_height, [95:88] colour, [96] use_colour, [104:97] pixel,
  // [111:105] zero
  input  logic [111:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]    in_tuser,
  // result channel
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] write_enable, [24:1] write_address, [32:25] write_value,
  // [57:33] pixel_count, [63:58] zero
  output logic [63:0]   out_tdata,
  // [1:0] status
  output logic [1:0]    out_tuser,
  output logic          out_tlast,
  // configuration write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_data
);

  // registers keep only the low coordinate bits, never more than the field
  localparam int unsigned CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

  localparam logic [CW-1:0] SW_RESET = CW'(640);
  localparam logic [CW-1:0] SH_RESET = CW'(480);
  localparam logic [CW-1:0] RP_RESET = CW'(640);

  logic [CW-1:0]  scr_w_r, scr_h_r, pitch_r;
  logic           in_v_r;
  logic [111:0]   in_data_r;
  logic [1:0]     in_cmd_r;
  logic           adv;
  logic           step_v;
  step_t          step;
  logic           out_v;
  logic [1:0]     res_status;
  logic           res_we;
  logic [ADDR_W-1:0]  res_addr;
  logic [PIXEL_W-1:0] res_value;
  logic [COUNT_W-1:0] res_count;
  logic           res_last;

  // whole pipeline moves together whenever the result slot is free
  assign adv       = !out_v || out_tready;
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SW_RESET;
      scr_h_r <= SH_RESET;
      pitch_r <= RP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data[CW-1:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data[CW-1:0];
        REG_ROW_PITCH:     pitch_r <= cfg_data[CW-1:0];
        default: begin
          // index out of range is ignored
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_cmd_r  <= in_tuser;
    end
  end

  // decode, clip and cursor stepping
  cfmb_engine #(
    .CW (CW)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_v          (in_v_r),
    .command       (in_cmd_r),
    .x_a           (in_data_r[15:0]),
    .y_a           (in_data_r[31:16]),
    .x_b           (in_data_r[47:32]),
    .y_b           (in_data_r[63:48]),
    .block_width   (in_data_r[64 +: CW]),
    .block_height  (in_data_r[76 +: CW]),
    .colour        (in_data_r[95:88]),
    .use_colour    (in_data_r[96]),
    .pixel         (in_data_r[104:97]),
    .screen_width  (scr_w_r),
    .screen_height (scr_h_r),
    .row_pitch     (pitch_r),
    .step_v_r      (step_v),
    .step_r        (step)
  );

  // address multiply and result register
  cfmb_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .step_v    (step_v),
    .step      (step),
    .row_pitch (FIELD_W'(pitch_r)),
    .out_v_r   (out_v),
    .status_r  (res_status),
    .we_r      (res_we),
    .addr_r    (res_addr),
    .value_r   (res_value),
    .count_r   (res_count),
    .last_r    (res_last)
  );

  assign out_tvalid = out_v;
  assign out_tuser  = res_status;
  assign out_tlast  = res_last;
  assign out_tdata  = {6'd0, res_count, res_value, res_addr, res_we};

`ifndef SYNTHESIS
  // the block only back-pressures while a result is held
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("request channel stalled without result stall");

  // a write is only produced by an accepted operation
  a_write_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_we) |-> (res_status == STAT_OK))
    else $error("write reported with non-ok status");

  // a result without a write carries zero address and value
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res_we) |-> ((res_addr == '0) && (res_value == '0)))
    else $error("address or value set without write");

  // a step record reaches the result register on the next advance
  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (step_v && adv) |=> out_v)
    else $error("step record lost on its way to the result register");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: scoreboard bench for the clipped fill and masked blit block
// Drives fill, blit and pixel requests with random idling on both streams,
// predicts every framebuffer write in step with each accepted request and
// checks the result stream in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cfmb_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int PIPE_LAT     = 2;     // request to result, sizes the settle wait in drain_writes
  localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int OP_PIXEL_CAP = 300;   // longer operations are cut short
  localparam int REPORT_MAX   = 10;

  // code that the block answers with a reject
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one request as the stimulus sees it
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] xa;
    logic [15:0] ya;
    logic [15:0] xb;
    logic [15:0] yb;
    logic [11:0] bw;
    logic [11:0] bh;
    logic [7:0]  colour;
    logic        use_colour;
    logic [7:0]  pixel;
  } blit_cmd_t;

  // one framebuffer write result
  typedef struct packed {
    logic [1:0]  status;
    logic        we;
    logic [23:0] addr;
    logic [7:0]  value;
    logic [24:0] count;
    logic        is_last;
  } fb_write_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [11:0]  cfg_data = '0;

  always #CLK_HALF clk = ~clk;

  clipped_fill_and_masked_blit_top #(
    .COORD_BITS(12)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor state: screen registers and operation tracking
  // --------------------------------------------------------------------------
  logic [11:0] scr_w = 12'd640;
  logic [11:0] scr_h = 12'd480;
  logic [11:0] scr_pitch = 12'd640;
  mode_t       op_mode = MODE_IDLE;
  logic [11:0] clip_l = '0, clip_t = '0, clip_r = '0, clip_b = '0;
  int          org_x = 0, org_y = 0;
  logic [11:0] span_w = '0, span_h = '0;
  logic [11:0] cur_col = '0, cur_row = '0;
  logic [7:0]  hold_colour = '0;
  logic        colour_mode = 1'b0;
  logic [24:0] wr_count = '0;

  fb_write_t pending_writes[$];  // writes predicted, not yet seen
  fb_write_t seen_write, want_write;
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        idling_on = 1'b1;

  function automatic bit screen_ok();
    return scr_w != 0 && scr_h != 0 && scr_pitch >= scr_w;
  endfunction

  // order the corners, clip to the screen; empty leaves the clip untouched
  function automatic bit clip_to_screen(int ax, int ay, int bx, int by);
    int lx, hx, ly, hy;
    lx = (ax < bx) ? ax : bx;
    hx = (ax > bx) ? ax : bx;
    ly = (ay < by) ? ay : by;
    hy = (ay > by) ? ay : by;
    if (hx < 0 || hy < 0 || lx >= int'(scr_w) || ly >= int'(scr_h)) return 1'b0;
    if (lx < 0) lx = 0;
    if (ly < 0) ly = 0;
    if (hx >= int'(scr_w)) hx = int'(scr_w) - 1;
    if (hy >= int'(scr_h)) hy = int'(scr_h) - 1;
    clip_l = lx[11:0];
    clip_t = ly[11:0];
    clip_r = hx[11:0];
    clip_b = hy[11:0];
    return 1'b1;
  endfunction

  function automatic logic [23:0] fb_addr(logic [11:0] col, logic [11:0] row);
    logic [63:0] full;
    full = 64'(row) * 64'(scr_pitch) + 64'(col);
    return full[23:0];
  endfunction

  // expected write for one accepted request, stepping the predictor state
  function automatic fb_write_t predict_fb_write(blit_cmd_t c);
    fb_write_t r;
    bit        ok;
    int        ax, ay, dx, dy;
    r = '0;
    r.status = STAT_OK;
    ok = 1'b0;
    ax = int'($signed(c.xa));
    ay = int'($signed(c.ya));
    case (c.cmd)
      CMD_FILL: begin
        if (screen_ok())
          ok = clip_to_screen(ax, ay, int'($signed(c.xb)), int'($signed(c.yb)));
        if (ok) begin
          op_mode = MODE_FILL;
          hold_colour = c.colour;
          cur_col = clip_l;
          cur_row = clip_t;
          wr_count = '0;
        end else begin
          op_mode = MODE_IDLE;
          r.status = STAT_REJECT;
        end
      end
      CMD_BLIT: begin
        if (c.bw != 0 && c.bh != 0 && screen_ok())
          ok = clip_to_screen(ax, ay, ax + int'(c.bw) - 1, ay + int'(c.bh) - 1);
        if (ok) begin
          op_mode = MODE_BLIT;
          org_x = ax;
          org_y = ay;
          span_w = c.bw;
          span_h = c.bh;
          cur_col = '0;
          cur_row = '0;
          hold_colour = c.colour;
          colour_mode = c.use_colour;
          wr_count = '0;
        end else begin
          op_mode = MODE_IDLE;
          r.status = STAT_REJECT;
        end
      end
      CMD_PIXEL: begin
        if (op_mode == MODE_FILL) begin
          r.we = 1'b1;
          r.addr = fb_addr(cur_col, cur_row);
          r.value = hold_colour;
          wr_count++;
          if (cur_col >= clip_r) begin
            if (cur_row >= clip_b) begin
              r.is_last = 1'b1;
              op_mode = MODE_IDLE;
            end else begin
              cur_col = clip_l;
              cur_row++;
            end
          end else begin
            cur_col++;
          end
          r.count = wr_count;
        end else if (op_mode == MODE_BLIT) begin
          dx = org_x + int'(cur_col);
          dy = org_y + int'(cur_row);
          // inside the clip, and masked out only on a zero pixel in colour mode
          if (dx >= int'(clip_l) && dx <= int'(clip_r) &&
              dy >= int'(clip_t) && dy <= int'(clip_b) &&
              (!colour_mode || c.pixel != 0)) begin
            r.we = 1'b1;
            r.addr = fb_addr(dx[11:0], dy[11:0]);
            r.value = colour_mode ? hold_colour : c.pixel;
            wr_count++;
          end
          if (int'(cur_col) + 1 >= int'(span_w)) begin
            if (int'(cur_row) + 1 >= int'(span_h)) begin
              r.is_last = 1'b1;
              op_mode = MODE_IDLE;
            end else begin
              cur_col = '0;
              cur_row++;
            end
          end else begin
            cur_col++;
          end
          r.count = wr_count;
        end else begin
          r.status = STAT_IDLE_PIXEL;
        end
      end
      default: r.status = STAT_REJECT;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------
  function automatic blit_cmd_t make_cmd(logic [1:0] cmd, logic [15:0] xa, logic [15:0] ya,
                                         logic [15:0] xb, logic [15:0] yb, logic [11:0] bw,
                                         logic [11:0] bh, logic [7:0] colour, logic use_colour,
                                         logic [7:0] pixel);
    blit_cmd_t c;
    c.cmd = cmd;
    c.xa = xa;
    c.ya = ya;
    c.xb = xb;
    c.yb = yb;
    c.bw = bw;
    c.bh = bh;
    c.colour = colour;
    c.use_colour = use_colour;
    c.pixel = pixel;
    return c;
  endfunction

  function automatic blit_cmd_t pixel_req(logic [7:0] px);
    return make_cmd(CMD_PIXEL, '0, '0, '0, '0, '0, '0, '0, 1'b0, px);
  endfunction

  // every field random, any code including the unused one
  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    c.cmd = 2'($urandom_range(0, 3));
    c.xa = 16'($urandom);
    c.ya = 16'($urandom);
    c.xb = 16'($urandom);
    c.yb = 16'($urandom);
    c.bw = 12'($urandom);
    c.bh = 12'($urandom);
    c.colour = 8'($urandom);
    c.use_colour = 1'($urandom);
    c.pixel = 8'($urandom);
    return c;
  endfunction

  // pixel request with random unused fields; zero pixels common in colour mode
  function automatic blit_cmd_t random_pixel_item();
    blit_cmd_t c;
    c = random_cmd();
    c.cmd = CMD_PIXEL;
    if (colour_mode && $urandom_range(0, 4) < 2) c.pixel = 8'h00;
    else if ($urandom_range(0, 9) == 0) c.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return c;
  endfunction

  // coordinate on the screen or just past its edges, now and then anywhere
  function automatic logic [15:0] near_coord(logic [11:0] span);
    int v;
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    v = $urandom_range(0, int'(span) + 8);
    return 16'(v - 4);
  endfunction

  function automatic logic [11:0] block_size();
    case ($urandom_range(0, 19))
      0:       return 12'($urandom);
      1:       return 12'd0;
      2, 3, 4: return 12'($urandom_range(9, 20));
      default: return 12'($urandom_range(1, 8));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request channel: one request per call, prediction at acceptance
  // valid stays high into the next call unless a gap is taken
  // --------------------------------------------------------------------------
  task automatic send_request(blit_cmd_t c);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.cmd;
    in_tdata <= {7'd0, c.pixel, c.use_colour, c.colour, c.bh, c.bw, c.yb, c.xb, c.ya, c.xa};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // unused codes and idle pixels do not count as work
    if (c.cmd == CMD_FILL || c.cmd == CMD_BLIT || (c.cmd == CMD_PIXEL && op_mode != MODE_IDLE))
      items_sent++;
    pending_writes.push_back(predict_fb_write(c));
  endtask

  // stop sending, let every predicted write come out, then let the pipe settle
  task automatic drain_writes();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // all three screen registers in one burst, only with the block drained
  task automatic set_screen(logic [11:0] w, logic [11:0] h, logic [11:0] p);
    logic [1:0]  regs [3] = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_ROW_PITCH};
    logic [11:0] vals [3];
    vals = '{w, h, p};
    drain_writes();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    scr_w = w;
    scr_h = h;
    scr_pitch = p;
  endtask

  // mostly whole operations with random content, some noise and cut-off runs
  task automatic run_random_ops(int budget);
    int        stop_at, remaining, n;
    blit_cmd_t c;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      c = random_cmd();
      case ($urandom_range(0, 9))
        0: ;  // noise request, taken as drawn
        1, 2, 3, 4: begin
          c.cmd = CMD_FILL;
          c.xa = near_coord(scr_w);
          c.ya = near_coord(scr_h);
          c.xb = ($urandom_range(0, 9) < 7) ? 16'(c.xa + $urandom_range(0, 12) - 6)
                                            : near_coord(scr_w);
          c.yb = ($urandom_range(0, 9) < 7) ? 16'(c.ya + $urandom_range(0, 12) - 6)
                                            : near_coord(scr_h);
        end
        default: begin
          c.cmd = CMD_BLIT;
          c.bw = block_size();
          c.bh = block_size();
          c.xa = near_coord(scr_w);
          c.ya = near_coord(scr_h);
        end
      endcase
      send_request(c);
      remaining = 0;
      if (c.cmd == CMD_FILL && op_mode == MODE_FILL)
        remaining = (int'(clip_r) - int'(clip_l) + 1) * (int'(clip_b) - int'(clip_t) + 1);
      else if (c.cmd == CMD_BLIT && op_mode == MODE_BLIT)
        remaining = int'(span_w) * int'(span_h);
      // huge ones are cut off by the next start, a few normal ones too
      if (remaining > OP_PIXEL_CAP) n = $urandom_range(1, 30);
      else if (remaining > 0 && $urandom_range(0, 11) == 0) n = $urandom_range(1, remaining);
      else n = remaining + (($urandom_range(0, 7) == 0) ? 1 : 0);
      repeat (n) send_request(random_pixel_item());
    end
    // a rejected start leaves the block idle before any register change
    if (op_mode != MODE_IDLE)
      send_request(make_cmd(CMD_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            '0, '0, '0, 1'b0, '0));
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall bursts, in-order checking, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, fb_write_t want, fb_write_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s: expected status=%0d we=%0b addr=%h value=%h count=%0d last=%0b",
               $time, what, want.status, want.we, want.addr, want.value, want.count,
               want.is_last,
               "\n    got status=%0d we=%0b addr=%h value=%h count=%0d last=%0b",
               got.status, got.we, got.addr, got.value, got.count, got.is_last);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_write = {out_tuser, out_tdata[0], out_tdata[24:1], out_tdata[32:25],
                    out_tdata[57:33], out_tlast};
      if (pending_writes.size() == 0) begin
        report_mismatch("result with no request pending", '0, seen_write);
      end else begin
        want_write = pending_writes.pop_front();
        if (seen_write !== want_write) report_mismatch("write mismatch", want_write, seen_write);
      end
    end
  end

  // any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // pixel with nothing running, and the unused command code
  task automatic test_idle_and_unused();
    send_request(pixel_req(8'hFF));
    send_request(make_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          12'hFFF, 12'hFFF, 8'hFF, 1'b1, 8'hFF));
  endtask

  // reversed corners clipped at the bottom-right, then two empty fills
  task automatic test_fill_clipping();
    send_request(make_cmd(CMD_FILL, 16'd641, 16'd481, 16'd637, 16'd478,
                          '0, '0, 8'hA5, 1'b0, '0));
    repeat (6) send_request(pixel_req(8'h00));
    // wholly above-left of the screen
    send_request(make_cmd(CMD_FILL, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                          '0, '0, 8'hFF, 1'b0, '0));
    // starts right of the last column
    send_request(make_cmd(CMD_FILL, 16'h7FFF, 16'd0, 16'd640, 16'h7FFF,
                          '0, '0, 8'h00, 1'b0, '0));
  endtask

  // rejects, a masked blit over the corner, a plain copy over the origin
  task automatic test_blit_modes();
    logic [7:0] masked_px [9] = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'h09, 8'hC8, 8'h03, 8'h00, 8'h4D};
    logic [7:0] copy_px [4] = '{8'hFF, 8'h07, 8'h80, 8'h00};
    send_request(make_cmd(CMD_BLIT, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                          12'hFFF, 12'hFFF, 8'hFF, 1'b1, 8'h00));
    // zero width
    send_request(make_cmd(CMD_BLIT, 16'd100, 16'd100, '0, '0, 12'd0, 12'd4,
                          8'h11, 1'b0, '0));
    send_request(make_cmd(CMD_BLIT, 16'd638, 16'd478, '0, '0, 12'd3, 12'd3,
                          8'hFF, 1'b1, '0));
    foreach (masked_px[i]) send_request(pixel_req(masked_px[i]));
    // only the last pixel, a zero, lands on screen
    send_request(make_cmd(CMD_BLIT, 16'hFFFF, 16'hFFFF, '0, '0, 12'd2, 12'd2,
                          8'h3C, 1'b0, '0));
    foreach (copy_px[i]) send_request(pixel_req(copy_px[i]));
  endtask

  // fixed screens: small, single pixel, wide pitch, each reject case, largest
  task automatic test_screen_settings();
    logic [11:0] ws [8] = '{12'd16, 12'd1, 12'd20, 12'd0, 12'd10, 12'd30, 12'd4095, 12'd4095};
    logic [11:0] hs [8] = '{12'd12, 12'd1, 12'd9, 12'd10, 12'd0, 12'd10, 12'd4095, 12'd2};
    logic [11:0] ps [8] = '{12'd16, 12'd1, 12'd37, 12'd10, 12'd10, 12'd29, 12'd4095, 12'd4095};
    int          budgets [8] = '{200, 60, 200, 15, 15, 15, 200, 80};
    for (int i = 0; i < 8; i++) begin
      set_screen(ws[i], hs[i], ps[i]);
      run_random_ops(budgets[i]);
    end
  endtask

  task automatic test_random_screens();
    logic [11:0] w;
    repeat (5) begin
      w = 12'($urandom_range(1, 40));
      set_screen(w, 12'($urandom_range(1, 40)), 12'(w + $urandom_range(0, 50)));
      run_random_ops(100);
    end
  endtask

  // back-to-back traffic, no idling on either stream
  task automatic test_steady_stream();
    set_screen(12'd24, 12'd16, 12'd24);
    idling_on = 1'b0;
    run_random_ops(200);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_unused();
    test_fill_clipping();
    test_blit_modes();
    test_screen_settings();
    test_random_screens();
    test_steady_stream();
    drain_writes();
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
